>>> hdl/slab_pkg.sv
package slab_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int ADDR_BITS_DEF   = 48;
    localparam int CMDQ_DEPTH      = 2;
    localparam int FIELD_ADDR_W    = 48;
    localparam int SIZE_W          = 17;
    localparam int ECNT_W          = 9;
    localparam int HDR_W           = 16;

    typedef enum logic [1:0] {
        OPC_ALLOC   = 2'd0,
        OPC_FREE    = 2'd1,
        OPC_RELEASE = 2'd2,
        OPC_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADFREE = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_BASE   = 2'd0,
        REG_SIZE   = 2'd1,
        REG_COUNT  = 2'd2,
        REG_HEADER = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_HDIV,
        BS_START,
        BS_SCAN,
        BS_MUL,
        BS_ADDR,
        BS_FLOAD,
        BS_FDIV,
        BS_FCHK,
        BS_OUT
    } t_bstate;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [FIELD_ADDR_W-1:0] free_address;
    } t_item;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] entry_address;
        logic [7:0]              entry_index;
        t_status                 status;
    } t_result;

    typedef struct packed {
        t_opcode                 op;
        logic [FIELD_ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] base_address;
        logic [SIZE_W-1:0]       entry_bytes;
        logic [ECNT_W-1:0]       entry_count;
        logic [HDR_W-1:0]        header_bytes;
    } t_cfg;

endpackage

>>> hdl/slab_front.sv
module slab_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  slab_pkg::t_item       i_item,
    output logic                  o_full,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output slab_pkg::t_cmd        o_q_cmd
);
    import slab_pkg::*;

    logic  r_valid, n_valid;
    t_cmd  r_cmd, n_cmd;
    logic  move, take;

    assign move     = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign take     = i_push && !o_full;
    assign o_q_push = move;
    assign o_q_cmd  = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (take) begin
            n_valid = 1'b1;
            n_cmd.addr = i_item.free_address;
            case (t_opcode'(i_item.opcode))
                OPC_ALLOC:   n_cmd.op = OPC_ALLOC;
                OPC_FREE:    n_cmd.op = OPC_FREE;
                OPC_RELEASE: n_cmd.op = OPC_RELEASE;
                default:     n_cmd.op = OPC_NOP;
            endcase
        end else if (move) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

>>> hdl/slab_cmdq.sv
module slab_cmdq #(
    parameter int DEPTH = slab_pkg::CMDQ_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slab_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output slab_pkg::t_cmd  o_cmd
);
    import slab_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> hdl/slab_back.sv
module slab_back #(
    parameter int MAX_ENTRIES = slab_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = slab_pkg::ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slab_pkg::t_cfg    i_cfg,
    input  logic              i_q_empty,
    input  slab_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output slab_pkg::t_result o_result
);
    import slab_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
    localparam int SCW    = (MAX_ENTRIES >= 16) ? 16 : MAX_ENTRIES;
    localparam int SB_W   = $clog2(MAX_ENTRIES + 2 * SCW + 1);
    localparam int DC_W   = $clog2(ADDR_BITS + 1);
    localparam int QW     = (ADDR_BITS > CW) ? ADDR_BITS : CW;
    localparam int PROD_W = IDX_W + SIZE_W;

    t_bstate                r_state, n_state;
    t_cmd                   r_cmd;
    logic [MAX_ENTRIES-1:0] r_map;
    logic [ADDR_BITS-1:0]   r_dvd;
    logic [SIZE_W-1:0]      r_rem;
    logic [DC_W-1:0]        r_dcnt;
    logic [ADDR_BITS-1:0]   r_start;
    logic [SB_W-1:0]        r_sbase;
    logic [IDX_W-1:0]       r_idx;
    logic [PROD_W-1:0]      r_prod;
    t_result                r_pend;
    t_result                r_res;
    logic                   r_res_valid;

    logic [SIZE_W-1:0]      sz;
    logic [CW-1:0]          cnt;
    logic [SIZE_W:0]        trial;
    logic                   qbit;
    logic [SIZE_W-1:0]      rem_next;
    logic                   found;
    logic [SB_W-1:0]        found_g;
    logic [SB_W-1:0]        g;
    logic [QW-1:0]          q_ext;
    logic                   fire_load;

    assign sz  = (i_cfg.entry_bytes == '0) ? SIZE_W'(1) : i_cfg.entry_bytes;
    assign cnt = (CW'(i_cfg.entry_count) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                            : CW'(i_cfg.entry_count);

    // one restoring-division step
    assign trial    = {r_rem, r_dvd[ADDR_BITS-1]};
    assign qbit     = (trial >= {1'b0, sz});
    assign rem_next = qbit ? SIZE_W'(trial - {1'b0, sz}) : SIZE_W'(trial);

    // first free entry in the current chunk
    always_comb begin
        found   = 1'b0;
        found_g = '0;
        for (int j = SCW - 1; j >= 0; j--) begin
            g = r_sbase + SB_W'(j);
            if ((g < SB_W'(cnt)) && !r_map[g[IDX_W-1:0]]) begin
                found   = 1'b1;
                found_g = g;
            end
        end
    end

    assign q_ext     = QW'(r_dvd);
    assign o_q_pop   = (r_state == BS_IDLE) && !i_q_empty;
    assign fire_load = o_q_pop;
    assign o_empty   = !r_res_valid;
    assign o_result  = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (fire_load) begin
                    if (i_q_cmd.op == OPC_ALLOC || i_q_cmd.op == OPC_FREE) begin
                        n_state = BS_HDIV;
                    end else begin
                        n_state = BS_OUT;
                    end
                end
            end
            BS_HDIV:  n_state = (r_dcnt == DC_W'(1)) ? BS_START : BS_HDIV;
            BS_START: n_state = (r_cmd.op == OPC_ALLOC) ? BS_SCAN : BS_FLOAD;
            BS_SCAN: begin
                if (found) begin
                    n_state = BS_MUL;
                end else if ((r_sbase + SB_W'(SCW)) >= SB_W'(cnt)) begin
                    n_state = BS_OUT;
                end
            end
            BS_MUL:   n_state = BS_ADDR;
            BS_ADDR:  n_state = BS_OUT;
            BS_FLOAD: n_state = BS_FDIV;
            BS_FDIV:  n_state = (r_dcnt == DC_W'(1)) ? BS_FCHK : BS_FDIV;
            BS_FCHK:  n_state = BS_OUT;
            BS_OUT:   n_state = (!r_res_valid || i_pop) ? BS_IDLE : BS_OUT;
            default:  n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_map       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_OUT && (!r_res_valid || i_pop)) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
            if (fire_load && i_q_cmd.op == OPC_RELEASE) begin
                r_map <= '0;
            end
            if (r_state == BS_SCAN && found) begin
                r_map[found_g[IDX_W-1:0]] <= 1'b1;
            end
            if (r_state == BS_FCHK && r_rem == '0 && q_ext < QW'(cnt)) begin
                r_map[r_dvd[IDX_W-1:0]] <= 1'b0;
            end
        end

        case (r_state)
            BS_IDLE: begin
                r_cmd  <= i_q_cmd;
                r_pend <= '{entry_address: '0, entry_index: '0, status: ST_OK};
                r_rem  <= '0;
                r_dcnt <= DC_W'(HDR_W);
                r_dvd  <= ADDR_BITS'(i_cfg.header_bytes) << (ADDR_BITS - HDR_W);
            end
            BS_HDIV, BS_FDIV: begin
                r_rem  <= rem_next;
                r_dvd  <= {r_dvd[ADDR_BITS-2:0], qbit};
                r_dcnt <= r_dcnt - 1'b1;
            end
            BS_START: begin
                r_start <= ADDR_BITS'(i_cfg.base_address) + ADDR_BITS'(i_cfg.header_bytes)
                         + ADDR_BITS'(sz - r_rem);
                r_sbase <= '0;
            end
            BS_SCAN: begin
                r_sbase <= r_sbase + SB_W'(SCW);
                r_idx   <= found_g[IDX_W-1:0];
                // report full only once the last chunk has come up empty
                if (!found && ((r_sbase + SB_W'(SCW)) >= SB_W'(cnt))) begin
                    r_pend.status <= ST_FULL;
                end
            end
            BS_MUL: begin
                r_prod <= PROD_W'(r_idx) * PROD_W'(sz);
            end
            BS_ADDR: begin
                r_pend.entry_address <= FIELD_ADDR_W'(r_start + ADDR_BITS'(r_prod));
                r_pend.entry_index   <= 8'(r_idx);
            end
            BS_FLOAD: begin
                r_dvd  <= ADDR_BITS'(r_cmd.addr) - r_start;
                r_rem  <= '0;
                r_dcnt <= DC_W'(ADDR_BITS);
            end
            BS_FCHK: begin
                if (r_rem != '0 || q_ext >= QW'(cnt)) begin
                    r_pend.status <= ST_BADFREE;
                end else begin
                    r_pend.entry_index <= 8'(r_dvd);
                end
            end
            BS_OUT: begin
                if (!r_res_valid || i_pop) begin
                    r_res <= r_pend;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

>>> hdl/slab_bitmap_allocator_core.sv
// Bitmap slab allocator, first fit, one used bit per entry.
// Requests enter through a queue-style port: drive i_item and raise push; the
// transfer happens on a clock edge with push high and full low. Opcode 0 takes
// the lowest free entry, 1 frees the entry at free_address, 2 releases all,
// 3 does nothing. Every request yields exactly one result, in request order,
// shown on o_result while empty is low and taken on an edge with pop high.
// A front stage decodes requests into a two-entry command queue; a back
// engine executes them one at a time and holds the result in an output
// register, so requests keep flowing in while a result waits to be taken.
// Release-all and nop go straight to the output stage; alloc takes a
// 16-step header remainder, then a 16-entry-per-cycle bitmap scan, a
// multiply and an add; free takes the header remainder, then the
// one-bit-per-cycle restoring divider that turns the offset back into an
// index. Queued requests overlap the front and queue stages, so new
// requests are taken in while the back engine works on an earlier one.
// Reset (synchronous, active low) frees every entry, empties both queues
// and loads the configuration defaults. A stalled receiver holds the result;
// the back engine then stops and the command queue fills up to raise full.
// Configuration is over an APB-style port, registers at 8-byte strides.
module slab_bitmap_allocator_core #(
    parameter int MAX_ENTRIES = slab_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = slab_pkg::ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  slab_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output slab_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import slab_pkg::*;

    t_cfg  r_cfg;
    t_reg  reg_sel;
    logic  cfg_wr;

    logic  q_full, q_push, q_empty, q_pop;
    t_cmd  front_cmd, q_cmd;

    // register file: index by the 8-byte slot, ignore the low byte lane bits
    assign reg_sel = t_reg'(paddr[4:3]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.entry_bytes  <= SIZE_W'(64);
            r_cfg.entry_count  <= '0;
            r_cfg.header_bytes <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_BASE:   r_cfg.base_address <= pwdata[FIELD_ADDR_W-1:0];
                REG_SIZE:   r_cfg.entry_bytes  <= pwdata[SIZE_W-1:0];
                REG_COUNT:  r_cfg.entry_count  <= pwdata[ECNT_W-1:0];
                REG_HEADER: r_cfg.header_bytes <= pwdata[HDR_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_BASE:   prdata = 64'(r_cfg.base_address);
            REG_SIZE:   prdata = 64'(r_cfg.entry_bytes);
            REG_COUNT:  prdata = 64'(r_cfg.entry_count);
            REG_HEADER: prdata = 64'(r_cfg.header_bytes);
            default:    prdata = '0;
        endcase
    end

    // decode stage: accept and classify requests
    slab_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (front_cmd)
    );

    // decouple decode from execution
    slab_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // execution engine: bitmap, divider, address math, result register
    slab_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

    // a failed request never carries an address
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_OK) |-> (o_result.entry_address == '0))
        else $error("failed request carries an address");

    // a rejected free reports no index
    a_bad_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == ST_BADFREE) |-> (o_result.entry_index == '0))
        else $error("rejected free carries an index");

    // nothing waits on the result side right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result pending after reset");

    // no status code beyond bad free is ever produced
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status != ST_RSVD))
        else $error("reserved status code");

endmodule
